// ===== hw/rtl/effp_pkg.sv =====
// effp_pkg: shared types and constants of the escaped field frame parser
// used by effp_cfg_regs and escaped_field_frame_parser; depends on nothing

package effp_pkg;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  localparam int DEF_MAX_HEADER_BYTES  = 8;
  localparam int DEF_MAX_TRAILER_BYTES = 8;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_LENGTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_STRING  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TRAILER_LENGTH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TRAILER_STRING = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR_BYTE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_BYTE    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_BYTE   = 3'd6;

  // register reset values
  localparam logic [3:0]            RST_HEADER_LENGTH  = 4'd1;
  localparam logic [CFG_DATA_W-1:0] RST_HEADER_STRING  = 64'd0;
  localparam logic [3:0]            RST_TRAILER_LENGTH = 4'd1;
  localparam logic [CFG_DATA_W-1:0] RST_TRAILER_STRING = 64'd35;
  localparam logic [7:0]            RST_SEPARATOR_BYTE = 8'd124;
  localparam logic [7:0]            RST_ESCAPE_BYTE    = 8'd92;
  localparam logic [7:0]            RST_COMMAND_BYTE   = 8'd35;

  // result kinds
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_DATA  = 3'd1;
  localparam logic [2:0] KIND_FIELD = 3'd2;
  localparam logic [2:0] KIND_OK    = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  typedef struct packed {
    logic [3:0] header_length;
    logic [3:0] trailer_length;
    logic [7:0] separator_byte;
    logic [7:0] escape_byte;
    logic [7:0] command_byte;
  } cfg_ctrl_t;

endpackage

// ===== hw/rtl/effp_cfg_regs.sv =====
// effp_cfg_regs: configuration register file of the frame parser
// depends on effp_pkg; strings keep only the bytes the parser can reach

module effp_cfg_regs #(
  parameter int MAX_HEADER_BYTES  = effp_pkg::DEF_MAX_HEADER_BYTES,
  parameter int MAX_TRAILER_BYTES = effp_pkg::DEF_MAX_TRAILER_BYTES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [effp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [effp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output effp_pkg::cfg_ctrl_t                ctrl,
  output logic [MAX_HEADER_BYTES*8-1:0]      header_str,
  output logic [MAX_TRAILER_BYTES*8-1:0]     trailer_str
);

  localparam int HDR_W = MAX_HEADER_BYTES * 8;
  localparam int TRL_W = MAX_TRAILER_BYTES * 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.header_length  <= effp_pkg::RST_HEADER_LENGTH;
      ctrl.trailer_length <= effp_pkg::RST_TRAILER_LENGTH;
      ctrl.separator_byte <= effp_pkg::RST_SEPARATOR_BYTE;
      ctrl.escape_byte    <= effp_pkg::RST_ESCAPE_BYTE;
      ctrl.command_byte   <= effp_pkg::RST_COMMAND_BYTE;
      header_str          <= effp_pkg::RST_HEADER_STRING[HDR_W-1:0];
      trailer_str         <= effp_pkg::RST_TRAILER_STRING[TRL_W-1:0];
    end else if (cfg_write) begin
      unique case (cfg_index)
        effp_pkg::REG_HEADER_LENGTH:  ctrl.header_length  <= cfg_data[3:0];
        effp_pkg::REG_HEADER_STRING:  header_str          <= cfg_data[HDR_W-1:0];
        effp_pkg::REG_TRAILER_LENGTH: ctrl.trailer_length <= cfg_data[3:0];
        effp_pkg::REG_TRAILER_STRING: trailer_str         <= cfg_data[TRL_W-1:0];
        effp_pkg::REG_SEPARATOR_BYTE: ctrl.separator_byte <= cfg_data[7:0];
        effp_pkg::REG_ESCAPE_BYTE:    ctrl.escape_byte    <= cfg_data[7:0];
        effp_pkg::REG_COMMAND_BYTE:   ctrl.command_byte   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/escaped_field_frame_parser.sv =====
// escaped_field_frame_parser: byte-stuffing deframer with field separator
// depends on effp_pkg and effp_cfg_regs
//
// Usage: one raw frame byte per request on the input channel (in_valid /
// in_stall), frame_begin high on the first byte of a frame. Every accepted
// byte yields exactly one result request on the output channel (out_valid /
// out_stall): nothing, a data byte, a field end, frame ok with the field
// count, or frame error. A frame is the header string, a separator, then
// fields split at unescaped separators; an unescaped command byte ends it
// and the raw bytes of the last field plus that byte must equal the trailer.
// out_valid rises in the cycle after input accept; one byte per cycle is
// sustained while the receiver does not stall, the parse step being a single
// compare-and-update stage between the input handshake and the result register.
// When the receiver stalls, the result register holds and in_stall rises
// in the same cycle; in_stall falls as soon as the held result is taken.
// Configuration writes go through cfg_write / cfg_index / cfg_data and
// take effect at the next cycle; write them only while the block is idle.
// Reset (rst, synchronous) restores the register defaults, empties the
// result register and leaves the parser idle waiting for frame_begin.

module escaped_field_frame_parser #(
  parameter int MAX_HEADER_BYTES  = effp_pkg::DEF_MAX_HEADER_BYTES,
  parameter int MAX_TRAILER_BYTES = effp_pkg::DEF_MAX_TRAILER_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        frame_byte,
  input  logic                              frame_begin,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        result_kind,
  output logic [7:0]                        data_byte,
  output logic [15:0]                       fields_in_frame,
  input  logic                              cfg_write,
  input  logic [effp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [effp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int HDR_W = MAX_HEADER_BYTES * 8;
  localparam int TRL_W = MAX_TRAILER_BYTES * 8;

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_SEP, PH_BODY} phase_t;

  effp_pkg::cfg_ctrl_t ctrl;
  logic [HDR_W-1:0]    header_str;
  logic [TRL_W-1:0]    trailer_str;

  effp_cfg_regs #(
    .MAX_HEADER_BYTES (MAX_HEADER_BYTES),
    .MAX_TRAILER_BYTES(MAX_TRAILER_BYTES)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctrl       (ctrl),
    .header_str (header_str),
    .trailer_str(trailer_str)
  );

  // parser state
  phase_t      phase, phase_next;
  logic [3:0]  header_pos, header_pos_next;
  logic        esc_pending, esc_pending_next;
  logic [3:0]  raw_len, raw_len_next;
  logic        field_match, field_match_next;
  logic [15:0] field_cnt, field_cnt_next;

  logic [2:0]  kind_next;
  logic [7:0]  data_next;
  logic [15:0] count_next;

  logic in_accept;
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // state as seen after a frame begin restart
  phase_t      cur_phase;
  logic [3:0]  cur_hpos;
  logic        cur_esc;
  logic [3:0]  cur_raw;
  logic        cur_match;
  logic [15:0] cur_cnt;

  logic [3:0]       hl, tl, tl_m1;
  logic [HDR_W-1:0] hdr_shift;
  logic [TRL_W-1:0] trl_pos_shift, trl_last_shift;
  logic [7:0]       hdr_byte, trl_pos_byte, trl_last_byte;
  logic [3:0]       raw_track;
  logic             match_track;
  logic             trailer_ok;

  always_comb begin
    cur_phase = frame_begin ? PH_HEADER : phase;
    cur_hpos  = frame_begin ? 4'd0 : header_pos;
    cur_esc   = frame_begin ? 1'b0 : esc_pending;
    cur_raw   = frame_begin ? 4'd0 : raw_len;
    cur_match = frame_begin ? 1'b1 : field_match;
    cur_cnt   = frame_begin ? 16'd0 : field_cnt;
  end

  always_comb begin
    hl = (ctrl.header_length > 4'(MAX_HEADER_BYTES)) ? 4'(MAX_HEADER_BYTES)
                                                     : ctrl.header_length;
    tl = (ctrl.trailer_length > 4'(MAX_TRAILER_BYTES)) ? 4'(MAX_TRAILER_BYTES)
                                                       : ctrl.trailer_length;
    tl_m1 = tl - 4'd1;
  end

  assign hdr_shift      = header_str >> {cur_hpos, 3'b000};
  assign hdr_byte       = hdr_shift[7:0];
  assign trl_pos_shift  = trailer_str >> {cur_raw, 3'b000};
  assign trl_pos_byte   = trl_pos_shift[7:0];
  assign trl_last_shift = trailer_str >> {tl_m1, 3'b000};
  assign trl_last_byte  = trl_last_shift[7:0];

  // raw byte tracking against the trailer prefix, length saturates
  assign match_track = cur_match & (tl != 4'd0) & (cur_raw < tl_m1) &
                       (frame_byte == trl_pos_byte);
  assign raw_track   = (cur_raw != 4'hF) ? cur_raw + 4'd1 : cur_raw;
  assign trailer_ok  = (tl != 4'd0) & cur_match & (cur_raw == tl_m1) &
                       (frame_byte == trl_last_byte);

  always_comb begin
    phase_next       = cur_phase;
    header_pos_next  = cur_hpos;
    esc_pending_next = cur_esc;
    raw_len_next     = cur_raw;
    field_match_next = cur_match;
    field_cnt_next   = cur_cnt;
    kind_next        = effp_pkg::KIND_NONE;
    data_next        = 8'd0;
    count_next       = 16'd0;

    if (cur_phase != PH_IDLE) begin
      // a header length lowered mid-header ends the header at once
      if (cur_phase == PH_HEADER && cur_hpos >= hl) phase_next = PH_SEP;

      priority if (frame_byte == 8'd0) begin
        kind_next = effp_pkg::KIND_ERR;
      end else if (phase_next == PH_HEADER) begin
        if (frame_byte != hdr_byte) begin
          kind_next = effp_pkg::KIND_ERR;
        end else begin
          header_pos_next = cur_hpos + 4'd1;
          if (cur_hpos + 4'd1 >= hl) phase_next = PH_SEP;
        end
      end else if (phase_next == PH_SEP) begin
        if (frame_byte != ctrl.separator_byte) begin
          kind_next = effp_pkg::KIND_ERR;
        end else begin
          phase_next       = PH_BODY;
          raw_len_next     = 4'd0;
          field_match_next = 1'b1;
        end
      end else if (cur_esc) begin
        esc_pending_next = 1'b0;
        raw_len_next     = raw_track;
        field_match_next = match_track;
        kind_next        = effp_pkg::KIND_DATA;
        data_next        = frame_byte;
      end else if (frame_byte == ctrl.separator_byte) begin
        if (cur_cnt != 16'hFFFF) field_cnt_next = cur_cnt + 16'd1;
        raw_len_next     = 4'd0;
        field_match_next = 1'b1;
        kind_next        = effp_pkg::KIND_FIELD;
      end else if (frame_byte == ctrl.escape_byte) begin
        raw_len_next     = raw_track;
        field_match_next = match_track;
        esc_pending_next = 1'b1;
      end else if (frame_byte == ctrl.command_byte) begin
        if (trailer_ok) begin
          kind_next  = effp_pkg::KIND_OK;
          count_next = cur_cnt;
          phase_next = PH_IDLE;
        end else begin
          kind_next = effp_pkg::KIND_ERR;
        end
      end else begin
        raw_len_next     = raw_track;
        field_match_next = match_track;
        kind_next        = effp_pkg::KIND_DATA;
        data_next        = frame_byte;
      end

      if (kind_next == effp_pkg::KIND_ERR) phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      header_pos  <= 4'd0;
      esc_pending <= 1'b0;
      raw_len     <= 4'd0;
      field_match <= 1'b1;
      field_cnt   <= 16'd0;
      out_valid   <= 1'b0;
    end else begin
      if (in_accept) begin
        phase           <= phase_next;
        header_pos      <= header_pos_next;
        esc_pending     <= esc_pending_next;
        raw_len         <= raw_len_next;
        field_match     <= field_match_next;
        field_cnt       <= field_cnt_next;
        out_valid       <= 1'b1;
        result_kind     <= kind_next;
        data_byte       <= data_next;
        fields_in_frame <= count_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // every accepted byte leaves a result in the output register
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted byte left no result");

  // an error always drops the parser back to idle
  a_error_idles: assert property (@(posedge clk) disable iff (rst)
    (in_accept && kind_next == effp_pkg::KIND_ERR) |=> phase == PH_IDLE)
    else $error("parser not idle after frame error");

  // field count only travels with frame ok, data byte only with data
  a_count_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind != effp_pkg::KIND_OK) |-> fields_in_frame == 16'd0)
    else $error("field count outside frame ok");

  a_data_only_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind != effp_pkg::KIND_DATA) |-> data_byte == 8'd0)
    else $error("data byte outside data result");

endmodule
